// File: sv/msp_pkg.sv
// msp_pkg: types and constants of the MSP v1 frame receiver.
// Shared by the interfaces, the parser, the read-out unit and the top level.
package msp_pkg;

  localparam logic [7:0] SYNC_DOLLAR = 8'h24;
  localparam logic [7:0] SYNC_M      = 8'h4D;
  localparam logic [7:0] DIR_REQ     = 8'h3C;
  localparam logic [7:0] DIR_RSP     = 8'h3E;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DELIVER_REQ = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DELIVER_RSP = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    P_IDLE,
    P_DOLLAR,
    P_GOT_M,
    P_LEN,
    P_CMD,
    P_DATA,
    P_SUM,
    P_SKIP
  } parse_state_e;

  typedef enum logic [1:0] {
    E_IDLE,
    E_READ,
    E_LOAD,
    E_SHOW
  } emit_state_e;

  // Frame header handed from the parser to the read-out unit
  typedef struct packed {
    logic       dir;
    logic [7:0] cmd;
    logic [6:0] len;
  } frame_t;

  typedef struct packed {
    logic       frame_direction;
    logic [7:0] command_code;
    logic [6:0] payload_length;
    logic [5:0] byte_index;
    logic [7:0] payload_byte;
    logic       last_of_run;
  } result_t;

endpackage

// File: sv/msp_if.sv
// Channel interfaces of the MSP frame receiver: received bytes, results
// and register writes. Depends on msp_pkg.
interface msp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface msp_res_if;
  logic       valid;
  logic       ready;
  logic       frame_direction;
  logic [7:0] command_code;
  logic [6:0] payload_length;
  logic [5:0] byte_index;
  logic [7:0] payload_byte;
  logic       last_of_run;
  modport source (output valid, output frame_direction, output command_code,
                  output payload_length, output byte_index, output payload_byte,
                  output last_of_run, input ready);
  modport sink (input valid, input frame_direction, input command_code,
                input payload_length, input byte_index, input payload_byte,
                input last_of_run, output ready);
endinterface

interface msp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [msp_pkg::CFG_IDX_W-1:0]      index;
  logic [msp_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/msp_ram.sv
// msp_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module msp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/msp_parser.sv
// msp_parser: byte-level frame parser; checks header and checksum and
// writes the payload into the store. Depends on msp_pkg.
module msp_parser #(
  parameter int unsigned MaxPayload = 64,
  parameter int unsigned AddrW      = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        rx_byte_i,
  output logic              in_ready_o,
  input  logic              emit_busy_i,
  input  logic              deliver_req_i,
  input  logic              deliver_rsp_i,
  output logic              ram_we_o,
  output logic [AddrW-1:0]  ram_waddr_o,
  output logic [7:0]        ram_wdata_o,
  output logic              start_o,
  output msp_pkg::frame_t   frame_o
);
  import msp_pkg::*;

  parse_state_e state_q, state_d;
  logic       dir_q;
  logic [7:0] len_q, csum_q, cnt_q, cmd_q;
  logic [7:0] cnt_inc;
  logic       acc;
  logic       sum_ok, dir_on;

  assign in_ready_o = !emit_busy_i;
  assign acc        = in_valid_i && in_ready_o;
  assign cnt_inc    = cnt_q + 8'd1;
  assign sum_ok     = (rx_byte_i == csum_q);
  assign dir_on     = dir_q ? deliver_rsp_i : deliver_req_i;

  always_comb begin
    state_d = state_q;
    if (acc) begin
      case (state_q)
        P_IDLE:   state_d = (rx_byte_i == SYNC_DOLLAR) ? P_DOLLAR : P_IDLE;
        P_DOLLAR: state_d = (rx_byte_i == SYNC_M) ? P_GOT_M : P_IDLE;
        P_GOT_M: begin
          if (rx_byte_i == DIR_REQ || rx_byte_i == DIR_RSP) begin
            state_d = P_LEN;
          end else begin
            state_d = P_IDLE;
          end
        end
        P_LEN: state_d = P_CMD;
        P_CMD: begin
          if (len_q > 8'(MaxPayload)) begin
            state_d = P_SKIP;
          end else if (len_q == 8'd0) begin
            state_d = P_SUM;
          end else begin
            state_d = P_DATA;
          end
        end
        P_DATA: state_d = (cnt_inc >= len_q) ? P_SUM : P_DATA;
        P_SUM:  state_d = P_IDLE;
        P_SKIP: state_d = (cnt_q >= len_q) ? P_IDLE : P_SKIP;
        default: state_d = P_IDLE;
      endcase
    end
  end

  always_comb begin
    ram_we_o = acc && (state_q == P_DATA);
    start_o  = acc && (state_q == P_SUM) && sum_ok && dir_on;
  end

  assign ram_waddr_o = cnt_q[AddrW-1:0];
  assign ram_wdata_o = rx_byte_i;
  assign frame_o     = '{dir: dir_q, cmd: cmd_q, len: len_q[6:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
      dir_q   <= 1'b0;
      len_q   <= 8'd0;
      csum_q  <= 8'd0;
      cnt_q   <= 8'd0;
      cmd_q   <= 8'd0;
    end else begin
      state_q <= state_d;
      if (acc) begin
        case (state_q)
          P_GOT_M: dir_q <= (rx_byte_i == DIR_RSP);
          P_LEN: begin
            len_q  <= rx_byte_i;
            csum_q <= rx_byte_i;
          end
          P_CMD: begin
            cmd_q  <= rx_byte_i;
            csum_q <= csum_q ^ rx_byte_i;
            cnt_q  <= 8'd0;
          end
          P_DATA: begin
            cnt_q  <= cnt_inc;
            csum_q <= csum_q ^ rx_byte_i;
          end
          P_SKIP: begin
            if (cnt_q < len_q) begin
              cnt_q <= cnt_inc;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// File: sv/msp_emitter.sv
// msp_emitter: reads a checked frame back from the payload store and
// presents it one result at a time. Depends on msp_pkg.
module msp_emitter #(
  parameter int unsigned AddrW = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  msp_pkg::frame_t   frame_i,
  output logic              busy_o,
  output logic              ram_re_o,
  output logic [AddrW-1:0]  ram_raddr_o,
  input  logic [7:0]        ram_rdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output msp_pkg::result_t  res_o
);
  import msp_pkg::*;

  emit_state_e state_q, state_d;
  frame_t      frame_q;
  logic [5:0]  idx_q;
  result_t     res_q;
  logic        empty, last;

  assign empty = (frame_q.len == 7'd0);
  assign last  = empty || (({1'b0, idx_q} + 7'd1) == frame_q.len);

  always_comb begin
    state_d = state_q;
    case (state_q)
      E_IDLE: state_d = start_i ? E_READ : E_IDLE;
      E_READ: state_d = E_LOAD;
      E_LOAD: state_d = E_SHOW;
      E_SHOW: begin
        if (out_ready_i) begin
          state_d = res_q.last_of_run ? E_IDLE : E_READ;
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_comb begin
    busy_o      = (state_q != E_IDLE);
    ram_re_o    = (state_q == E_READ);
    out_valid_o = (state_q == E_SHOW);
  end

  assign ram_raddr_o = idx_q[AddrW-1:0];
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      idx_q   <= 6'd0;
    end else begin
      state_q <= state_d;
      if (state_q == E_IDLE && start_i) begin
        idx_q <= 6'd0;
      end else if (state_q == E_SHOW && out_ready_i) begin
        idx_q <= idx_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == E_IDLE && start_i) begin
      frame_q <= frame_i;
    end
    if (state_q == E_LOAD) begin
      res_q.frame_direction <= frame_q.dir;
      res_q.command_code    <= frame_q.cmd;
      res_q.payload_length  <= frame_q.len;
      res_q.byte_index      <= empty ? 6'd0 : idx_q;
      res_q.payload_byte    <= empty ? 8'd0 : ram_rdata_i;
      res_q.last_of_run     <= last;
    end
  end

endmodule

// File: sv/msp_frame_receiver.sv
// Frame receiver for MSP v1 ('$' 'M' dir len cmd payload csum). Received
// bytes are taken one per cycle while the parser runs; ready drops only
// while a checked frame is read out of the payload store. Each result
// goes through the address, the registered RAM read and the output
// register, and waits there on any output stall; the input is held
// until the frame's last result is taken. Bad headers, bad checksums,
// oversize frames and frames of a disabled direction produce no results.
// Depends on msp_pkg, msp_if, msp_ram, msp_parser and msp_emitter.
module msp_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  msp_rx_if.sink    rx_i,
  msp_res_if.source res_o,
  msp_cfg_if.sink   cfg_i
);
  import msp_pkg::*;

  localparam int unsigned AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic             deliver_req_q, deliver_rsp_q;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;
  logic             start, emit_busy;
  frame_t           frame;
  result_t          res;

  // Register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deliver_req_q <= 1'b0;
      deliver_rsp_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_DELIVER_REQ: deliver_req_q <= cfg_i.data[0];
        REG_DELIVER_RSP: deliver_rsp_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  msp_parser #(
    .MaxPayload (MAX_PAYLOAD),
    .AddrW      (AddrW)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (rx_i.valid),
    .rx_byte_i     (rx_i.rx_byte),
    .in_ready_o    (rx_i.ready),
    .emit_busy_i   (emit_busy),
    .deliver_req_i (deliver_req_q),
    .deliver_rsp_i (deliver_rsp_q),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .start_o       (start),
    .frame_o       (frame)
  );

  msp_ram #(
    .Width (8),
    .Depth (MAX_PAYLOAD),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  msp_emitter #(
    .AddrW (AddrW)
  ) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .frame_i     (frame),
    .busy_o      (emit_busy),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .res_o       (res)
  );

  assign res_o.frame_direction = res.frame_direction;
  assign res_o.command_code    = res.command_code;
  assign res_o.payload_length  = res.payload_length;
  assign res_o.byte_index      = res.byte_index;
  assign res_o.payload_byte    = res.payload_byte;
  assign res_o.last_of_run     = res.last_of_run;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for msp_frame_receiver. It sends MSP v1 byte streams and
// tracks frames itself; every result read out is checked field by field against its copy.
// Depends on msp_pkg, the channel interfaces in msp_if and the receiver RTL.
module tb_top;
  import msp_pkg::*;

  localparam int unsigned PAYLOAD_CAP   = 64;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned PHASE_BYTES   = 16;
  localparam int unsigned SETTLE_CYCLES = 12;

  // Indexes past the register list; writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = CFG_IDX_W'(15);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_MID = CFG_IDX_W'(10);

  typedef enum int unsigned {
    PH_HUNT,
    PH_SAW_DOLLAR,
    PH_SAW_M,
    PH_GET_LEN,
    PH_GET_CMD,
    PH_GET_DATA,
    PH_GET_SUM,
    PH_DISCARD
  } rx_phase_e;

  class msp_frame_tracker;
    bit        take_req;
    bit        take_rsp;
    rx_phase_e phase;
    bit        is_rsp;
    bit [7:0]  want_len;
    bit [7:0]  csum;
    bit [7:0]  count;
    bit [7:0]  cmd;
    bit [7:0]  payload_copy [PAYLOAD_CAP];
    result_t   pending_results [$];
    int        errors;

    function new();
      take_req = 1'b0;
      take_rsp = 1'b0;
      phase    = PH_HUNT;
      is_rsp   = 1'b0;
      want_len = '0;
      csum     = '0;
      count    = '0;
      cmd      = '0;
      errors   = 0;
      foreach (payload_copy[i]) payload_copy[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DELIVER_REQ: take_req = val[0];
        REG_DELIVER_RSP: take_rsp = val[0];
        default: ;
      endcase
    endfunction

    function void note_byte(bit [7:0] b);
      int unsigned n;
      result_t     r;
      case (phase)
        PH_HUNT: phase = (b == SYNC_DOLLAR) ? PH_SAW_DOLLAR : PH_HUNT;
        PH_SAW_DOLLAR: phase = (b == SYNC_M) ? PH_SAW_M : PH_HUNT;
        PH_SAW_M: begin
          if (b == DIR_REQ) begin
            is_rsp = 1'b0;
            phase  = PH_GET_LEN;
          end else if (b == DIR_RSP) begin
            is_rsp = 1'b1;
            phase  = PH_GET_LEN;
          end else begin
            phase = PH_HUNT;
          end
        end
        PH_GET_LEN: begin
          want_len = b;
          csum     = b;
          phase    = PH_GET_CMD;
        end
        PH_GET_CMD: begin
          count = '0;
          cmd   = b;
          csum  = csum ^ b;
          if (want_len > PAYLOAD_CAP) phase = PH_DISCARD;
          else if (want_len == 0) phase = PH_GET_SUM;
          else phase = PH_GET_DATA;
        end
        PH_GET_DATA: begin
          payload_copy[count[5:0]] = b;
          count = count + 8'd1;
          csum  = csum ^ b;
          if (count >= want_len) phase = PH_GET_SUM;
        end
        PH_GET_SUM: begin
          phase = PH_HUNT;
          if ((csum ^ b) == 8'h00 && (is_rsp ? take_rsp : take_req)) begin
            n = (want_len == 0) ? 1 : 32'(want_len);
            for (int unsigned k = 0; k < n; k++) begin
              r.frame_direction = is_rsp;
              r.command_code    = cmd;
              r.payload_length  = want_len[6:0];
              r.byte_index      = (want_len == 0) ? 6'd0 : k[5:0];
              r.payload_byte    = (want_len == 0) ? 8'd0 : payload_copy[k[5:0]];
              r.last_of_run     = (k + 1 == n);
              pending_results.push_back(r);
            end
          end
        end
        PH_DISCARD: begin
          if (count >= want_len) phase = PH_HUNT;
          else count = count + 8'd1;
        end
        default: phase = PH_HUNT;
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: cmd 0x%0h index %0d", got.command_code, got.byte_index);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("frame_direction", 32'(want.frame_direction), 32'(got.frame_direction));
      compare_field("command_code", 32'(want.command_code), 32'(got.command_code));
      compare_field("payload_length", 32'(want.payload_length), 32'(got.payload_length));
      compare_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
      compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
      compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  msp_rx_if  rx_if ();
  msp_res_if res_if ();
  msp_cfg_if cfg_if ();

  msp_frame_receiver uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  msp_frame_tracker tracker = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_sent     = 0;
  int unsigned cycle_count    = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: check on each accepted result, then pick the next ready
  initial begin
    result_t got;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready) begin
        got.frame_direction = res_if.frame_direction;
        got.command_code    = res_if.command_code;
        got.payload_length  = res_if.payload_length;
        got.byte_index      = res_if.byte_index;
        got.payload_byte    = res_if.payload_byte;
        got.last_of_run     = res_if.last_of_run;
        tracker.check_result(got);
      end
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Leaves valid high on return; the caller either sends again or drops it
  task automatic send_byte(input bit [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    tracker.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_seq(input bit [7:0] seq [$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic send_frame(input bit rsp, input bit [7:0] len, input bit [7:0] cmd,
                            input bit spoil_sum);
    bit [7:0] seq [$];
    bit [7:0] sum;
    bit [7:0] d;
    seq = '{SYNC_DOLLAR, SYNC_M, rsp ? DIR_RSP : DIR_REQ, len, cmd};
    sum = len ^ cmd;
    for (int unsigned i = 0; i < len; i++) begin
      d = 8'($urandom_range(255));
      seq.push_back(d);
      sum = sum ^ d;
    end
    if (spoil_sum) sum = sum ^ 8'($urandom_range(255, 1));
    seq.push_back(sum);
    send_seq(seq);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  // Drop the byte request, wait out pending results and any silent frame work
  task automatic drain();
    rx_if.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] req_val,
                           input logic [CFG_DATA_W-1:0] rsp_val,
                           input int unsigned idle_pct, input int unsigned stall_pct,
                           input bit stray_writes);
    int unsigned start_count;
    int unsigned pick;
    bit [7:0]    len;
    bit [7:0]    seq [$];
    drain();
    write_reg(REG_DELIVER_REQ, req_val);
    write_reg(REG_DELIVER_RSP, rsp_val);
    if (stray_writes) begin
      write_reg(REG_SPARE_HI, 8'hFF);
      write_reg(REG_SPARE_MID, 8'h00);
    end
    cfg_if.valid   <= 1'b0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_count    = bytes_sent;
    while (bytes_sent - start_count < PHASE_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        // mostly short frames, now and then up to a full store
        if ($urandom_range(9) < 8) len = 8'($urandom_range(8));
        else if ($urandom_range(9) == 0) len = 8'(PAYLOAD_CAP);
        else len = 8'($urandom_range(PAYLOAD_CAP, 9));
        send_frame(1'($urandom_range(1)), len, 8'($urandom_range(255)), pick >= 55);
      end else if (pick < 72) begin
        len = ($urandom_range(30) == 0) ? 8'd255 : 8'($urandom_range(72, 65));
        send_frame(1'($urandom_range(1)), len, 8'($urandom_range(255)),
                   1'($urandom_range(1)));
      end else if (pick < 85) begin
        seq = '{SYNC_DOLLAR};
        if ($urandom_range(1)) seq.push_back(SYNC_M);
        seq.push_back(8'($urandom_range(255)));
        send_seq(seq);
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    rx_if.valid    <= 1'b0;
    rx_if.rx_byte  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= '0;
    cfg_if.data    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_DELIVER_REQ, 8'h01);
    write_reg(REG_DELIVER_RSP, 8'h01);
    cfg_if.valid <= 1'b0;

    // empty request, empty response, byte extremes, bad sum, broken headers
    send_seq('{SYNC_DOLLAR, SYNC_M, DIR_REQ, 8'h00, 8'h00, 8'h00});
    send_seq('{SYNC_DOLLAR, SYNC_M, DIR_RSP, 8'h00, 8'hFF, 8'hFF});
    send_seq('{SYNC_DOLLAR, SYNC_M, DIR_REQ, 8'h02, 8'h5A, 8'h00, 8'hFF, 8'hA7});
    send_seq('{SYNC_DOLLAR, SYNC_M, DIR_RSP, 8'h00, 8'h10, 8'h11});
    send_seq('{SYNC_DOLLAR, 8'h58, SYNC_DOLLAR, SYNC_M, 8'h21});
    send_frame(1'b1, 8'(PAYLOAD_CAP), 8'h3C, 1'b0);
    send_frame(1'b0, 8'(PAYLOAD_CAP + 1), 8'hC3, 1'b0);

    run_phase(8'h01, 8'h01, 0, 0, 1'b0);
    run_phase(8'hFF, 8'hFE, 73, 0, 1'b0);
    run_phase(8'h80, 8'h7F, 0, 73, 1'b1);
    run_phase(8'h00, 8'h00, 16, 16, 1'b0);
    run_phase(8'h01, 8'h01, 16, 16, 1'b0);
    drain();
    repeat (20) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
